// ----- rtl/hte_pkg.sv -----
// Shared types, constants and a helper function for the homography transfer error scorer.
package hte_pkg;

    localparam int unsigned MAX_POINTS = 65536;
    localparam logic [16:0] TALLY_CAP = (MAX_POINTS < 131071) ? 17'(MAX_POINTS) : 17'd131071;
    localparam logic [39:0] RES_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [62:0] HROW0_RST = 63'd262144;
    localparam logic [62:0] HROW1_RST = 63'd549755813888;
    localparam logic [62:0] HROW2_RST = 63'd1152921504606846976;
    localparam logic [39:0] LIMIT_RST = 40'd6554;

    localparam logic [1:0] REG_HROW0 = 2'd0;
    localparam logic [1:0] REG_HROW1 = 2'd1;
    localparam logic [1:0] REG_HROW2 = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COF,
        ST_PROJ,
        ST_CHK,
        ST_DIV,
        ST_SQ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic signed [51:0] num;
        logic signed [51:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    // Flat coefficient indexes {i1, i2, i3, i4} of cofactor k: h[i1]*h[i2] - h[i3]*h[i4].
    function automatic logic [15:0] cof_idx(input logic [3:0] k);
        logic [15:0] r;
        case (k)
            4'd0: r = {4'd4, 4'd8, 4'd5, 4'd7};
            4'd1: r = {4'd2, 4'd7, 4'd1, 4'd8};
            4'd2: r = {4'd1, 4'd5, 4'd2, 4'd4};
            4'd3: r = {4'd5, 4'd6, 4'd3, 4'd8};
            4'd4: r = {4'd0, 4'd8, 4'd2, 4'd6};
            4'd5: r = {4'd2, 4'd3, 4'd0, 4'd5};
            4'd6: r = {4'd3, 4'd7, 4'd4, 4'd6};
            4'd7: r = {4'd1, 4'd6, 4'd0, 4'd7};
            4'd8: r = {4'd0, 4'd4, 4'd1, 4'd3};
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/hte_div.sv -----
// Restoring divider giving a signed Q.16 quotient with its magnitude capped at 2^30.
module hte_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  hte_pkg::div_req_t req,
    output hte_pkg::div_rsp_t rsp
);

    logic [67:0] rem_reg, rem_next;
    logic [81:0] dv_reg, dv_next;
    logic [30:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [50:0] num_mag, den_mag;
    logic        ge;
    logic [30:0] mag;

    always_comb
    begin
        num_mag = req.num[51] ? 51'(-req.num) : req.num[50:0];
        den_mag = req.den[51] ? 51'(-req.den) : req.den[50:0];
        ge = ({14'd0, rem_reg} >= dv_reg);
        rem_next = rem_reg;
        dv_next = dv_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = {1'b0, num_mag, 16'd0};
            dv_next = {1'b0, den_mag, 30'd0};
            q_next = '0;
            cnt_next = 5'd30;
            busy_next = 1'b1;
            neg_next = req.num[51] ^ req.den[51];
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dv_reg[67:0];
            end
            q_next = {q_reg[29:0], ge};
            dv_next = dv_reg >> 1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg <= dv_next;
        q_reg <= q_next;
        neg_reg <= neg_next;
    end

    // An integer part of 2^14 or more sets the top quotient bit and selects the cap.
    assign mag = q_reg[30] ? 31'h4000_0000 : {1'b0, q_reg[29:0]};
    assign rsp.done = done_reg;
    assign rsp.quo = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// ----- rtl/homography_transfer_error_scorer.sv -----
// Top level of the homography symmetric transfer error scorer.
//
// channel  direction  handshake          payload
// s        in         s_tvalid/s_tready  s_tdata: points, s_tuser: first_of_set
// m        out        m_tvalid/m_tready  m_tdata: residue, total; m_tuser: flags
// config   in         wr_en              wr_index, wr_data
//
// One correspondence is worked in steps: multiply and accumulate steps for the adjugate,
// then for both projections, then eight divisions on the shared restoring divider;
// four squares and a finish follow.
// A point at infinity skips the divisions and the squares.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register, and the next word may be taken meanwhile.
// Reset loads the identity homography and the default limit and clears the tally.
module homography_transfer_error_scorer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // src_x, src_y, src_w, dst_x, dst_y, dst_w
    input  logic [0:0]   s_tuser,   // first_of_set
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // residue, inlier_total, zero fill
    output logic [1:0]   m_tuser,   // is_inlier, at_infinity
    input  logic         wr_en,
    input  logic [1:0]   wr_index,
    input  logic [62:0]  wr_data
);

    hte_pkg::state_t state_reg, state_next;
    logic [3:0]  k_reg, k_next;
    logic [1:0]  c_reg, c_next;
    logic        g_reg, g_next;
    logic        ph_reg, ph_next;

    logic [62:0] hrow_reg [3];
    logic [39:0] limit_reg;
    logic [16:0] tally_reg, tally_next;

    logic signed [23:0] pt_reg [6];
    logic               first_reg;
    logic signed [24:0] a_reg [9];
    logic signed [51:0] q_reg [6];
    logic signed [31:0] quo_reg [8];
    logic signed [59:0] acc_reg, acc_next;
    logic signed [59:0] prod_reg;
    logic               ok_reg, ok_next;
    logic               inf_reg, inf_next;

    logic               out_valid_reg;
    logic [39:0]        out_res_reg;
    logic [16:0]        out_total_reg;
    logic               out_inl_reg, out_inf_reg;

    logic signed [20:0] h [9];
    logic signed [29:0] ma, mb;
    logic [15:0]        cidx;
    logic [3:0]         flat;
    logic signed [32:0] d;
    logic [32:0]        d_mag;
    logic signed [59:0] cof_diff;
    logic signed [59:0] cof_rnd;
    logic signed [59:0] acc_sum;
    logic [43:0]        res_sh;
    logic [39:0]        residue;
    logic               inl;
    logic [16:0]        tally_base;
    logic               accept, load_out;
    logic [2:0]         q_idx;
    hte_pkg::div_req_t  dreq;
    hte_pkg::div_rsp_t  drsp;

    hte_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                h[r * 3 + c] = hrow_reg[r][c * 21 +: 21];
            end
        end
    end

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == hte_pkg::ST_IDLE);
    assign flat = 4'({k_reg[1:0], 1'b0}) + 4'(k_reg[1:0]) + 4'(c_reg);
    assign q_idx = g_reg ? 3'(k_reg[1:0]) + 3'd3 : 3'(k_reg[1:0]);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        cidx = hte_pkg::cof_idx(k_reg);
        case (k_reg[1:0])
            2'd0: d = quo_reg[4] - quo_reg[2];
            2'd1: d = quo_reg[5] - quo_reg[3];
            2'd2: d = quo_reg[6] - quo_reg[0];
            default: d = quo_reg[7] - quo_reg[1];
        endcase
        d_mag = d[32] ? 33'(-d) : d;
        ma = '0;
        mb = '0;
        case (state_reg)
            hte_pkg::ST_COF:
            begin
                if (c_reg[0])
                begin
                    ma = 30'(h[cidx[7:4]]);
                    mb = 30'(h[cidx[3:0]]);
                end
                else
                begin
                    ma = 30'(h[cidx[15:12]]);
                    mb = 30'(h[cidx[11:8]]);
                end
            end
            hte_pkg::ST_PROJ:
            begin
                if (g_reg)
                begin
                    ma = 30'(a_reg[flat]);
                    mb = 30'(pt_reg[3'(c_reg) + 3'd3]);
                end
                else
                begin
                    ma = 30'(h[flat]);
                    mb = 30'(pt_reg[3'(c_reg)]);
                end
            end
            hte_pkg::ST_SQ:
            begin
                ma = d[29:0];
                mb = d[29:0];
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
    end

    always_comb
    begin
        cof_diff = acc_reg - prod_reg;
        cof_rnd = (cof_diff + 60'sd131072) >>> 18;
        acc_sum = acc_reg + prod_reg;
        res_sh = acc_reg[59:16];
        if (inf_reg || !ok_reg || (res_sh[43:40] != 4'd0))
        begin
            residue = hte_pkg::RES_MAX;
        end
        else
        begin
            residue = res_sh[39:0];
        end
        inl = !inf_reg && (residue < limit_reg);
        tally_base = first_reg ? 17'd0 : tally_reg;
        tally_next = (inl && tally_base < hte_pkg::TALLY_CAP) ? tally_base + 17'd1 : tally_base;
        load_out = (state_reg == hte_pkg::ST_DONE) && (!out_valid_reg || m_tready);
    end

    always_comb
    begin
        dreq.start = (state_reg == hte_pkg::ST_DIV) && !ph_reg;
        case (k_reg[2:0])
            3'd0: begin dreq.num = 52'(pt_reg[0]); dreq.den = 52'(pt_reg[2]); end
            3'd1: begin dreq.num = 52'(pt_reg[1]); dreq.den = 52'(pt_reg[2]); end
            3'd2: begin dreq.num = 52'(pt_reg[3]); dreq.den = 52'(pt_reg[5]); end
            3'd3: begin dreq.num = 52'(pt_reg[4]); dreq.den = 52'(pt_reg[5]); end
            3'd4: begin dreq.num = q_reg[0]; dreq.den = q_reg[2]; end
            3'd5: begin dreq.num = q_reg[1]; dreq.den = q_reg[2]; end
            3'd6: begin dreq.num = q_reg[3]; dreq.den = q_reg[5]; end
            default: begin dreq.num = q_reg[4]; dreq.den = q_reg[5]; end
        endcase
    end

    // Sequencer: in each multiply step the product is registered first and then accumulated.
    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        c_next = c_reg;
        g_next = g_reg;
        ph_next = ph_reg;
        acc_next = acc_reg;
        ok_next = ok_reg;
        inf_next = inf_reg;
        case (state_reg)
            hte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = hte_pkg::ST_COF;
                    k_next = '0;
                    c_next = '0;
                    g_next = 1'b0;
                    ph_next = 1'b0;
                end
            end
            hte_pkg::ST_COF:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (!c_reg[0])
                    begin
                        acc_next = prod_reg;
                        c_next = 2'd1;
                    end
                    else
                    begin
                        c_next = 2'd0;
                        if (k_reg == 4'd8)
                        begin
                            state_next = hte_pkg::ST_PROJ;
                            k_next = '0;
                        end
                        else
                        begin
                            k_next = k_reg + 4'd1;
                        end
                    end
                end
            end
            hte_pkg::ST_PROJ:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    acc_next = (c_reg == 2'd0) ? prod_reg : acc_sum;
                    if (c_reg == 2'd2)
                    begin
                        c_next = 2'd0;
                        if (k_reg == 4'd2)
                        begin
                            k_next = '0;
                            if (g_reg)
                            begin
                                state_next = hte_pkg::ST_CHK;
                            end
                            g_next = !g_reg;
                        end
                        else
                        begin
                            k_next = k_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 2'd1;
                    end
                end
            end
            hte_pkg::ST_CHK:
            begin
                inf_next = (pt_reg[2] == 24'sd0) || (pt_reg[5] == 24'sd0) ||
                           (q_reg[2] == 52'sd0) || (q_reg[5] == 52'sd0);
                ok_next = 1'b1;
                k_next = '0;
                ph_next = 1'b0;
                state_next = inf_next ? hte_pkg::ST_DONE : hte_pkg::ST_DIV;
            end
            hte_pkg::ST_DIV:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (drsp.done)
                begin
                    ph_next = 1'b0;
                    if (k_reg == 4'd7)
                    begin
                        k_next = '0;
                        state_next = hte_pkg::ST_SQ;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            hte_pkg::ST_SQ:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    acc_next = (k_reg == 4'd0) ? prod_reg : acc_sum;
                    if (d_mag >= 33'h1000_0000)
                    begin
                        ok_next = 1'b0;
                    end
                    if (k_reg == 4'd3)
                    begin
                        state_next = hte_pkg::ST_DONE;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            hte_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = hte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hte_pkg::ST_IDLE;
            k_reg <= '0;
            c_reg <= '0;
            g_reg <= 1'b0;
            ph_reg <= 1'b0;
            hrow_reg[0] <= hte_pkg::HROW0_RST;
            hrow_reg[1] <= hte_pkg::HROW1_RST;
            hrow_reg[2] <= hte_pkg::HROW2_RST;
            limit_reg <= hte_pkg::LIMIT_RST;
            tally_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            c_reg <= c_next;
            g_reg <= g_next;
            ph_reg <= ph_next;
            if (wr_en)
            begin
                case (wr_index)
                    hte_pkg::REG_HROW0: hrow_reg[0] <= wr_data;
                    hte_pkg::REG_HROW1: hrow_reg[1] <= wr_data;
                    hte_pkg::REG_HROW2: hrow_reg[2] <= wr_data;
                    hte_pkg::REG_LIMIT: limit_reg <= wr_data[39:0];
                    default: limit_reg <= limit_reg;
                endcase
            end
            if (load_out)
            begin
                tally_reg <= tally_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ok_reg <= ok_next;
        inf_reg <= inf_next;
        if (accept)
        begin
            for (int i = 0; i < 6; i++)
            begin
                pt_reg[i] <= s_tdata[i * 24 +: 24];
            end
            first_reg <= s_tuser[0];
        end
        if (state_reg == hte_pkg::ST_COF && ph_reg && c_reg[0])
        begin
            a_reg[k_reg] <= cof_rnd[24:0];
        end
        if (state_reg == hte_pkg::ST_PROJ && ph_reg && c_reg == 2'd2)
        begin
            q_reg[q_idx] <= acc_sum[51:0];
        end
        if (state_reg == hte_pkg::ST_DIV && ph_reg && drsp.done)
        begin
            quo_reg[k_reg[2:0]] <= drsp.quo;
        end
        if (load_out)
        begin
            out_res_reg <= residue;
            out_total_reg <= tally_next;
            out_inl_reg <= inl;
            out_inf_reg <= inf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, out_total_reg, out_res_reg};
    assign m_tuser = {out_inf_reg, out_inl_reg};

`ifndef ASSERT_OFF
    a_inf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[39:0] == hte_pkg::RES_MAX && !m_tuser[0])
        else $error("point at infinity without saturated residue");
    a_tally_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= hte_pkg::TALLY_CAP)
        else $error("inlier tally above its cap");
    a_inlier_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[56:40] != 17'd0)
        else $error("inlier reported with an empty tally");
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |=> state_reg == hte_pkg::ST_DIV)
        else $error("division started outside the division phase");
`endif

endmodule
